/* hw/rtl/afc_pkg.sv */
// shared types and constants for the box versus frustum classifier
package afc_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int PLANE_REGS     = 6;
	localparam int CORNERS        = 8;
	localparam int COORD_W        = 16;
	localparam int Q_SHIFT        = 14;
	localparam int PROD_W         = 2 * COORD_W;
	localparam int DQ_W           = COORD_W + Q_SHIFT;
	localparam int SUM_W          = PROD_W + 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int IN_TDATA_W     = 6 * COORD_W;
	localparam int OUT_TDATA_W    = 8;

	// packed as in the plane register: a lowest, d highest
	typedef struct packed {
		logic [COORD_W-1:0] d;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] a;
	} plane_t;

	// packed as on the input stream: min_x lowest
	typedef struct packed {
		logic [COORD_W-1:0] max_z;
		logic [COORD_W-1:0] max_y;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] min_z;
		logic [COORD_W-1:0] min_y;
		logic [COORD_W-1:0] min_x;
	} box_t;

	// per plane partial products, all signed two's complement
	typedef struct packed {
		logic [PROD_W-1:0] ax_lo;
		logic [PROD_W-1:0] ax_hi;
		logic [PROD_W-1:0] by_lo;
		logic [PROD_W-1:0] by_hi;
		logic [PROD_W-1:0] cz_lo;
		logic [PROD_W-1:0] cz_hi;
		logic [DQ_W-1:0]   d_q;
	} prod_t;

	typedef enum logic [1:0] {
		VIS_OUTSIDE   = 2'd0,
		VIS_INTERSECT = 2'd1,
		VIS_INSIDE    = 2'd2
	} vis_t;

endpackage

/* hw/rtl/afc_plane_regs.sv */
// plane coefficient register file written through the configuration channel
module afc_plane_regs (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [afc_pkg::CFG_IDX_W-1:0]             wr_index,
	input  logic [afc_pkg::CFG_DATA_W-1:0]            wr_data,
	output afc_pkg::plane_t [afc_pkg::PLANE_REGS-1:0] planes
);

	afc_pkg::plane_t [afc_pkg::PLANE_REGS-1:0] planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < afc_pkg::PLANE_REGS; i++) begin
				if (wr_index == afc_pkg::CFG_IDX_W'(i)) begin
					planes_q[i] <= afc_pkg::plane_t'(wr_data);
				end
			end
		end
	end

	assign planes = planes_q;

	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_index == '0) |=> planes_q[0] == $past(wr_data))
		else $error("plane 0 write not stored");

	a_high_index_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_index >= afc_pkg::CFG_IDX_W'(afc_pkg::PLANE_REGS)) |=> $stable(planes_q))
		else $error("write beyond the plane registers changed a plane");

endmodule

/* hw/rtl/afc_product_stage.sv */
// coefficient by coordinate products for every plane, registered
module afc_product_stage #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  afc_pkg::box_t                       box,
	input  afc_pkg::plane_t [NUM_PLANES-1:0]    planes,
	output logic                                out_valid,
	input  logic                                out_ready,
	output afc_pkg::prod_t [NUM_PLANES-1:0]     prod
);

	function automatic logic signed [afc_pkg::PROD_W-1:0] mul_coord(
		input logic signed [afc_pkg::COORD_W-1:0] coef,
		input logic signed [afc_pkg::COORD_W-1:0] coord
	);
		return coef * coord;
	endfunction

	afc_pkg::prod_t [NUM_PLANES-1:0] prod_d;
	afc_pkg::prod_t [NUM_PLANES-1:0] prod_s2;
	logic                            valid_s2;

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			prod_d[p].ax_lo = mul_coord(planes[p].a, box.min_x);
			prod_d[p].ax_hi = mul_coord(planes[p].a, box.max_x);
			prod_d[p].by_lo = mul_coord(planes[p].b, box.min_y);
			prod_d[p].by_hi = mul_coord(planes[p].b, box.max_y);
			prod_d[p].cz_lo = mul_coord(planes[p].c, box.min_z);
			prod_d[p].cz_hi = mul_coord(planes[p].c, box.max_z);
			prod_d[p].d_q   = {planes[p].d, {afc_pkg::Q_SHIFT{1'b0}}};
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s2 <= prod_d;
		end
	end

	assign out_valid = valid_s2;
	assign prod      = prod_s2;

endmodule

/* hw/rtl/afc_classify_stage.sv */
// corner sums, sign tests and the registered visibility result
module afc_classify_stage #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  afc_pkg::prod_t [NUM_PLANES-1:0] prod,
	output logic                            out_valid,
	input  logic                            out_ready,
	output afc_pkg::vis_t                   vis
);

	function automatic logic corner_pos(
		input logic signed [afc_pkg::PROD_W-1:0] ax,
		input logic signed [afc_pkg::PROD_W-1:0] by,
		input logic signed [afc_pkg::PROD_W-1:0] cz,
		input logic signed [afc_pkg::DQ_W-1:0]   dq
	);
		logic signed [afc_pkg::SUM_W-1:0] s;
		s = ax + by + cz + dq;
		return !s[afc_pkg::SUM_W-1] && (s != '0);
	endfunction

	logic [NUM_PLANES-1:0]        any_pos;
	logic [NUM_PLANES-1:0]        all_pos;
	logic [afc_pkg::CORNERS-1:0]  pos [NUM_PLANES];
	afc_pkg::vis_t                vis_d;
	afc_pkg::vis_t                vis_s3;
	logic                         valid_s3;

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int k = 0; k < afc_pkg::CORNERS; k++) begin
				pos[p][k] = corner_pos(
					k[0] ? prod[p].ax_hi : prod[p].ax_lo,
					k[1] ? prod[p].by_hi : prod[p].by_lo,
					k[2] ? prod[p].cz_hi : prod[p].cz_lo,
					prod[p].d_q);
			end
			any_pos[p] = |pos[p];
			all_pos[p] = &pos[p];
		end
	end

	always_comb begin
		priority if (!(&any_pos)) begin
			vis_d = afc_pkg::VIS_OUTSIDE;
		end else if (&all_pos) begin
			vis_d = afc_pkg::VIS_INSIDE;
		end else begin
			vis_d = afc_pkg::VIS_INTERSECT;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vis_s3 <= vis_d;
		end
	end

	assign out_valid = valid_s3;
	assign vis       = vis_s3;

endmodule

/* hw/rtl/aabb_frustum_classify_unit.sv */
// top level of the axis-aligned box versus frustum classifier
// Classifies each incoming box (min and max corners, signed 16-bit) against the first
// NUM_PLANES of six planes held in configuration registers: 0 when some plane has no
// corner on its positive side, 2 when all eight corners are positive for every plane,
// 1 otherwise. Planes are a, b, c in signed Q2.14 and d a signed integer scaled by 2^14;
// the test a*x + b*y + c*z + d > 0 is exact. The unit is a three-register pipeline
// (input register, product register, result register) and takes one box per clock
// unless the output is held; a result passes through those registers in order, and a held
// output stalls every stage. A box reads the planes when it moves into the product
// register, so the user must write planes only while no box is in flight (the block does
// not enforce this); indexes six and seven are dropped, and reset clears every plane.
module aabb_frustum_classify_unit #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z
	input  logic [afc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// visibility, zero fill
	output logic [afc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	afc_pkg::plane_t [afc_pkg::PLANE_REGS-1:0] planes;
	afc_pkg::box_t                             box_s1;
	logic                                      valid_s1;
	logic                                      prod_ready;
	logic                                      prod_valid;
	logic                                      cls_ready;
	afc_pkg::prod_t [NUM_PLANES-1:0]           prod;
	afc_pkg::vis_t                             vis;

	assign cfg_ready = 1'b1;

	afc_plane_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.planes   (planes)
	);

	assign s_axis_tready = !valid_s1 || prod_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			box_s1 <= afc_pkg::box_t'(s_axis_tdata);
		end
	end

	afc_product_stage #(
		.NUM_PLANES (NUM_PLANES)
	) u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (prod_ready),
		.box       (box_s1),
		.planes    (planes[NUM_PLANES-1:0]),
		.out_valid (prod_valid),
		.out_ready (cls_ready),
		.prod      (prod)
	);

	afc_classify_stage #(
		.NUM_PLANES (NUM_PLANES)
	) u_cls (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (cls_ready),
		.prod      (prod),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.vis       (vis)
	);

	assign m_axis_tdata = {{(afc_pkg::OUT_TDATA_W - 2){1'b0}}, vis};

	a_in_transfer_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("input transfer did not fill the input register");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && prod_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted with every stage held");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input refused with an empty input register");

endmodule
